// ===== design/bitmap_rotate_nearest_assert.svh =====
// ---------------------------------------------------------------------------
// bitmap_rotate_nearest_assert: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef BITMAP_ROTATE_NEAREST_ASSERT_SVH
`define BITMAP_ROTATE_NEAREST_ASSERT_SVH

// same-cycle implication
`define BRN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BRN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/brn_pkg.sv =====
// ---------------------------------------------------------------------------
// brn_pkg: shared types for the bitmap rotator
// Command word passed from the classifier to the datapath, and geometry.
// ---------------------------------------------------------------------------
package brn_pkg;

    localparam int COORD_W = 6;

    // what the datapath does with a queued word
    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_FETCH,
        KIND_MISS
    } t_kind;

    // classified command word
    typedef struct packed {
        t_kind                kind;
        logic signed [7:0]    i;
        logic signed [7:0]    j;
        logic [COORD_W-1:0]   col;
        logic [COORD_W-1:0]   row;
    } t_cmd;

    // rotation and effective bitmap size
    typedef struct packed {
        logic signed [15:0] cos_q;
        logic signed [15:0] sin_q;
        logic [6:0]         width_used;
        logic [6:0]         height_used;
    } t_geom;

endpackage

// ===== design/bitmap_rotate_nearest.sv =====
// A fetch word goes from the queue through the offset, product, sum and store stages to its result.
// Throughput: one word per cycle unless stalled, set by the single write and read port of the store.
// A write takes the same path and is in the store before any later fetch reads it.
// Reset: queue and pipeline empty, registers back to cos 1.0, sin 0, 64 by 64.
// The pixel store is not cleared by reset; no clearing pass is run.
// ---------------------------------------------------------------------------
// bitmap_rotate_nearest: nearest-neighbour bitmap rotation about the centre
// Classifier, word queue and rotation datapath with the source pixel store.
// ---------------------------------------------------------------------------
module bitmap_rotate_nearest import brn_pkg::*; #(
    parameter int MAX_SIDE   = 64,
    parameter int PIXEL_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_func,
    input  logic [COORD_W-1:0]    i_col,
    input  logic [COORD_W-1:0]    i_row,
    input  logic [PIXEL_BITS-1:0] i_pixel_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [PIXEL_BITS-1:0] o_pixel_out,
    output logic                  o_hit,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

    localparam logic [1:0] CFG_COS    = 2'd0;
    localparam logic [1:0] CFG_SIN    = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;
    localparam int         QDEPTH     = 4;
    localparam int         QW         = $bits(t_cmd) + PIXEL_BITS;
    localparam logic [8:0] SIDE9      = 9'(MAX_SIDE);

    logic signed [15:0]    r_cos_q;
    logic signed [15:0]    r_sin_q;
    logic [6:0]            r_width_used;
    logic [6:0]            r_height_used;
    t_geom                 geom;

    logic                  keep;
    t_cmd                  front_cmd;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;
    logic [QW-1:0]         q_out;
    t_cmd                  back_cmd;
    logic [PIXEL_BITS-1:0] back_pixel;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_q       <= 16'sd16384;
            r_sin_q       <= 16'sd0;
            r_width_used  <= 7'd64;
            r_height_used <= 7'd64;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COS:    r_cos_q       <= i_cfg_data;
                CFG_SIN:    r_sin_q       <= i_cfg_data;
                CFG_WIDTH:  r_width_used  <= i_cfg_data[6:0];
                CFG_HEIGHT: r_height_used <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // effective geometry, sizes capped at the store side
    always_comb begin
        geom.cos_q       = r_cos_q;
        geom.sin_q       = r_sin_q;
        geom.width_used  = ({2'b0, r_width_used} > SIDE9) ? SIDE9[6:0] : r_width_used;
        geom.height_used = ({2'b0, r_height_used} > SIDE9) ? SIDE9[6:0] : r_height_used;
    end

    // front: classify accepted words
    brn_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_func (i_func),
        .i_col  (i_col),
        .i_row  (i_row),
        .i_geom (geom),
        .o_keep (keep),
        .o_cmd  (front_cmd)
    );

    assign o_stall = q_full;
    assign q_push  = i_valid && !q_full && keep;

    // queue between front and back
    brn_queue #(
        .WIDTH (QW),
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({front_cmd, i_pixel_in}),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign back_cmd   = q_out[QW-1:PIXEL_BITS];
    assign back_pixel = q_out[PIXEL_BITS-1:0];

    // back: rotation datapath and store
    brn_back #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (geom),
        .i_empty     (q_empty),
        .i_cmd       (back_cmd),
        .i_pixel     (back_pixel),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel_out (o_pixel_out),
        .o_hit       (o_hit)
    );

endmodule

// ===== design/brn_ram.sv =====
// ---------------------------------------------------------------------------
// brn_ram: generic simple dual-port ram
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module brn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/brn_front.sv =====
// ---------------------------------------------------------------------------
// brn_front: word classifier
// Sorts incoming words into writes, in-range fetches and misses and forms
// the centred destination offsets.
// ---------------------------------------------------------------------------
module brn_front import brn_pkg::*; #(
    parameter int MAX_SIDE = 64
) (
    input  logic               i_func,
    input  logic [COORD_W-1:0] i_col,
    input  logic [COORD_W-1:0] i_row,
    input  t_geom              i_geom,
    output logic               o_keep,
    output t_cmd               o_cmd
);

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;
    localparam logic [8:0] SIDE9 = 9'(MAX_SIDE);

    logic [5:0] half_w;
    logic [5:0] half_h;
    logic       dest_ok;
    logic       write_ok;

    // halves of the size and destination range check
    assign half_w   = i_geom.width_used[6:1];
    assign half_h   = i_geom.height_used[6:1];
    assign dest_ok  = ({1'b0, i_col} < {half_w, 1'b0}) &&
                      ({1'b0, i_row} < {half_h, 1'b0});
    assign write_ok = ({3'b0, i_col} < SIDE9) && ({3'b0, i_row} < SIDE9);

    // classification
    always_comb begin
        o_cmd.i   = $signed({2'b0, i_col}) - $signed({2'b0, half_w});
        o_cmd.j   = $signed({2'b0, i_row}) - $signed({2'b0, half_h});
        o_cmd.col = i_col;
        o_cmd.row = i_row;
        unique case (i_func)
            FUNC_WRITE: begin
                o_cmd.kind = KIND_WRITE;
                o_keep     = write_ok;
            end
            FUNC_FETCH: begin
                o_cmd.kind = dest_ok ? KIND_FETCH : KIND_MISS;
                o_keep     = 1'b1;
            end
            default: begin
                o_cmd.kind = KIND_MISS;
                o_keep     = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/brn_queue.sv =====
// ---------------------------------------------------------------------------
// brn_queue: short word queue
// Decouples the classifier from the datapath so each side stalls alone.
// ---------------------------------------------------------------------------
`include "bitmap_rotate_nearest_assert.svh"

module brn_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    `BRN_ASSERT_NOW(a_pop_nonempty, i_pop, r_count != '0, "pop from empty queue")
    `BRN_ASSERT_NEXT(a_push_counts, i_push && !i_pop, r_count == $past(r_count) + CW'(1), "push lost")

endmodule

// ===== design/brn_back.sv =====
// ---------------------------------------------------------------------------
// brn_back: rotation datapath
// Four stages: offsets, products, coordinate sums and bounds, store access.
// ---------------------------------------------------------------------------
`include "bitmap_rotate_nearest_assert.svh"

module brn_back import brn_pkg::*; #(
    parameter int MAX_SIDE   = 64,
    parameter int PIXEL_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_geom                 i_geom,
    input  logic                  i_empty,
    input  t_cmd                  i_cmd,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [PIXEL_BITS-1:0] o_pixel_out,
    output logic                  o_hit
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);

    logic                  advance;

    logic                  r_s1_valid;
    t_cmd                  r_s1_cmd;
    logic [PIXEL_BITS-1:0] r_s1_pixel;

    logic                  r_s2_valid;
    t_kind                 r_s2_kind;
    logic signed [23:0]    r_s2_ic, r_s2_js, r_s2_jc, r_s2_is;
    logic [COORD_W-1:0]    r_s2_col, r_s2_row;
    logic [PIXEL_BITS-1:0] r_s2_pixel;
    logic signed [23:0]    n_ic, n_js, n_jc, n_is;

    logic                  r_s3_valid;
    t_kind                 r_s3_kind;
    logic                  r_s3_hit;
    logic [6:0]            r_s3_xi, r_s3_yi;
    logic [PIXEL_BITS-1:0] r_s3_pixel;
    logic signed [25:0]    sx, sy;
    logic                  x_in, y_in;
    logic                  n_hit;
    logic [6:0]            n_xi, n_yi;

    logic                  r_s4_valid;
    logic                  r_s4_hit;
    logic [AW-1:0]         ram_addr;
    logic                  ram_we;
    logic [PIXEL_BITS-1:0] ram_q;

    // whole pipe moves unless a result waits on a stalled output
    assign advance = !(r_s4_valid && i_stall);
    assign o_pop   = advance && !i_empty;

    // stage 2 products
    assign n_ic = $signed(r_s1_cmd.i) * i_geom.cos_q;
    assign n_js = $signed(r_s1_cmd.j) * i_geom.sin_q;
    assign n_jc = $signed(r_s1_cmd.j) * i_geom.cos_q;
    assign n_is = $signed(r_s1_cmd.i) * i_geom.sin_q;

    // stage 3 source coordinates in q.14 and bounds
    always_comb begin
        sx = $signed({{2{r_s2_ic[23]}}, r_s2_ic}) + $signed({{2{r_s2_js[23]}}, r_s2_js})
           + $signed({6'd0, i_geom.width_used, 13'd0});
        sy = $signed({{2{r_s2_jc[23]}}, r_s2_jc}) - $signed({{2{r_s2_is[23]}}, r_s2_is})
           + $signed({6'd0, i_geom.height_used, 13'd0});
        x_in  = (sx > -26'sd16384) && (sx < $signed({5'd0, i_geom.width_used, 14'd0}));
        y_in  = (sy > -26'sd16384) && (sy < $signed({5'd0, i_geom.height_used, 14'd0}));
        n_hit = (r_s2_kind == KIND_FETCH) && x_in && y_in;
        if (r_s2_kind == KIND_WRITE) begin
            n_xi = {1'b0, r_s2_col};
            n_yi = {1'b0, r_s2_row};
        end else begin
            n_xi = sx[25] ? 7'd0 : sx[20:14];
            n_yi = sy[25] ? 7'd0 : sy[20:14];
        end
    end

    // stage 4 store address, shared by writes and fetches
    assign ram_addr = AW'(32'(r_s3_yi) * 32'(MAX_SIDE) + 32'(r_s3_xi));
    assign ram_we   = advance && r_s3_valid && (r_s3_kind == KIND_WRITE);

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s3_hit   <= 1'b0;
            r_s4_hit   <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= !i_empty;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s3_hit   <= r_s2_valid && n_hit;
            r_s4_valid <= r_s3_valid && (r_s3_kind != KIND_WRITE);
            r_s4_hit   <= r_s3_valid && r_s3_hit;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_cmd   <= i_cmd;
            r_s1_pixel <= i_pixel;
            r_s2_kind  <= r_s1_cmd.kind;
            r_s2_ic    <= n_ic;
            r_s2_js    <= n_js;
            r_s2_jc    <= n_jc;
            r_s2_is    <= n_is;
            r_s2_col   <= r_s1_cmd.col;
            r_s2_row   <= r_s1_cmd.row;
            r_s2_pixel <= r_s1_pixel;
            r_s3_kind  <= r_s2_kind;
            r_s3_xi    <= n_xi;
            r_s3_yi    <= n_yi;
            r_s3_pixel <= r_s2_pixel;
        end
    end

    // source pixel store
    brn_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (r_s3_pixel),
        .i_re    (advance),
        .i_raddr (ram_addr),
        .o_rdata (ram_q)
    );

    // result word
    assign o_valid     = r_s4_valid;
    assign o_hit       = r_s4_hit;
    assign o_pixel_out = r_s4_hit ? ram_q : '0;

    `BRN_ASSERT_NOW(a_hit_is_fetch, r_s3_hit, r_s3_valid && (r_s3_kind == KIND_FETCH), "hit on non-fetch")
    `BRN_ASSERT_NEXT(a_write_silent, advance && r_s3_valid && (r_s3_kind == KIND_WRITE), !r_s4_valid, "write made a result")

endmodule

// ===== bench/rotate_check_pkg.sv =====
// ---------------------------------------------------------------------------
// rotate_check_pkg: checking support for the bitmap rotator bench
// Word and register codes, and a scoreboard that keeps its own copy of the
// rotation registers and pixel store, predicts each fetch and checks results.
// ---------------------------------------------------------------------------
package rotate_check_pkg;

    localparam int SIDE      = 64;
    localparam int MEM_DEPTH = SIDE * SIDE;
    localparam int ONE_Q     = 16384;

    // input word function
    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_FETCH = 1'b1
    } t_func;

    // configuration register index
    typedef enum logic [1:0] {
        REG_COS    = 2'd0,
        REG_SIN    = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } t_reg_index;

    // one expected fetch result, coordinates kept for messages
    typedef struct packed {
        logic [7:0] pixel;
        logic       hit;
        logic [5:0] col;
        logic [5:0] row;
    } t_fetch_result;

    class rotate_scoreboard;
        shortint       cos_q;
        shortint       sin_q;
        logic [6:0]    width_used;
        logic [6:0]    height_used;
        logic [7:0]    pixel_mem [MEM_DEPTH];
        bit            pixel_known [MEM_DEPTH];
        t_fetch_result expected_q [$];
        int            n_noted;
        int            n_errors;

        function new();
            cos_q       = ONE_Q;
            sin_q       = 0;
            width_used  = 7'd64;
            height_used = 7'd64;
            n_noted     = 0;
            n_errors    = 0;
            foreach (pixel_known[k]) pixel_known[k] = 1'b0;
        endfunction

        function void set_reg(t_reg_index idx, logic [15:0] data);
            case (idx)
                REG_COS:    cos_q       = $signed(data);
                REG_SIN:    sin_q       = $signed(data);
                REG_WIDTH:  width_used  = data[6:0];
                REG_HEIGHT: height_used = data[6:0];
                default: ;
            endcase
        endfunction

        // sizes above the store side are clipped to it
        function int side_of(logic [6:0] s);
            return (s > SIDE) ? SIDE : int'(s);
        endfunction

        // truncate a Q.14 coordinate toward zero and test it against the side
        function bit in_span(longint q, int side, output int idx);
            idx = 0;
            if (q <= -longint'(ONE_Q) || q >= longint'(side) * ONE_Q) return 1'b0;
            idx = (q >= 0) ? int'(q / ONE_Q) : 0;
            return 1'b1;
        endfunction

        // source address sampled by a fetch, 0 returned on a miss
        function bit locate(logic [5:0] col, logic [5:0] row, output int unsigned addr);
            int     w;
            int     h;
            int     hw;
            int     hh;
            int     xi;
            int     yi;
            longint i;
            longint j;
            longint sx;
            longint sy;
            addr = 0;
            w    = side_of(width_used);
            h    = side_of(height_used);
            hw   = w / 2;
            hh   = h / 2;
            // odd last column or row, tiny and out-of-range destinations
            if (int'(col) >= 2 * hw || int'(row) >= 2 * hh) return 1'b0;
            i  = longint'(col) - hw;
            j  = longint'(row) - hh;
            sx = i * cos_q + j * sin_q + longint'(w) * 8192;
            sy = j * cos_q - i * sin_q + longint'(h) * 8192;
            if (!in_span(sx, w, xi)) return 1'b0;
            if (!in_span(sy, h, yi)) return 1'b0;
            addr = yi * SIDE + xi;
            return 1'b1;
        endfunction

        // accepted input word: update the store or queue the fetch result
        function void note_word(t_func func, logic [5:0] col, logic [5:0] row,
                                logic [7:0] pix);
            t_fetch_result r;
            int unsigned   addr;
            n_noted++;
            if (func == FUNC_WRITE) begin
                pixel_mem[row * SIDE + col]   = pix;
                pixel_known[row * SIDE + col] = 1'b1;
            end else begin
                r.col   = col;
                r.row   = row;
                r.hit   = locate(col, row, addr);
                r.pixel = r.hit ? pixel_mem[addr] : 8'd0;
                expected_q.push_back(r);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            if (n_errors < 100) $display("MISMATCH @%0t: %s", $time, msg);
            n_errors++;
        endtask

        task check_result(logic [7:0] pix, logic hit);
            t_fetch_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("result pixel %0h hit %0b with no fetch pending", pix, hit));
                return;
            end
            want = expected_q.pop_front();
            if (hit !== want.hit)
                report($sformatf("fetch (%0d,%0d) hit %0b, want %0b",
                                 want.col, want.row, hit, want.hit));
            if (pix !== want.pixel)
                report($sformatf("fetch (%0d,%0d) pixel %0h, want %0h",
                                 want.col, want.row, pix, want.pixel));
        endtask

        task close_out();
            if (expected_q.size() != 0)
                report($sformatf("%0d fetch results never arrived", expected_q.size()));
        endtask
    endclass

endpackage

// ===== bench/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: regression bench for bitmap_rotate_nearest
// Directed words over sizes, angles and edge cases, then random phases under
// bursty input and a stalling receiver, all checked against the scoreboard.
// ---------------------------------------------------------------------------
module tb_top;
    import rotate_check_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE       = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_WORD = 600;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       o_stall;
    logic       i_func      = 1'b0;
    logic [5:0] i_col       = '0;
    logic [5:0] i_row       = '0;
    logic [7:0] i_pixel_in  = '0;
    logic       o_valid;
    logic       i_stall     = 1'b0;
    logic [7:0] o_pixel_out;
    logic       o_hit;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    int cycle_count = 0;
    int burst_left  = 0;

    rotate_scoreboard sb = new();

    bitmap_rotate_nearest DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_pixel_in  (i_pixel_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel_out (o_pixel_out),
        .o_hit       (o_hit),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_pixel_out, o_hit);
    end

    // receiver: stall patterns in segments, one long hold-off
    initial begin : receiver
        int  seg;
        int  mode;
        bit  held;
        held = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && sb.n_noted >= HOLD_AT_WORD) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(8, 64);
            repeat (seg) begin
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= $urandom_range(0, 1);
                    2: i_stall <= ($urandom_range(0, 4) != 0);
                    default: i_stall <= cycle_count[1];
                endcase
                @(posedge i_clk);
            end
        end
    end

    // one input word, bursts with random gaps
    task automatic send_word(t_func func, logic [5:0] col, logic [5:0] row,
                             logic [7:0] pix);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid    <= 1'b1;
        i_func     <= func;
        i_col      <= col;
        i_row      <= row;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (o_stall);
        sb.note_word(func, col, row, pix);
    endtask

    // fetch, loading its source pixel first if it was never written
    task automatic send_fetch(logic [5:0] col, logic [5:0] row);
        int unsigned src;
        if (sb.locate(col, row, src) && !sb.pixel_known[src])
            send_word(FUNC_WRITE, src[5:0], src[11:6], 8'($urandom_range(0, 255)));
        send_word(FUNC_FETCH, col, row, 8'($urandom_range(0, 255)));
    endtask

    // stop offering and wait until every fetch has answered
    task automatic drain_results();
        i_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // reprogram all registers while idle
    task automatic program_regs(int c, int s, int w, int h);
        logic [15:0] val [4];
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        val[0] = 16'(c);
        val[1] = 16'(s);
        val[2] = 16'(w & 8'h7f);
        val[3] = 16'(h & 8'h7f);
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_reg_index'(k);
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_reg(t_reg_index'(k), val[k]);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // random phase: mostly fetches inside the destination, some writes
    task automatic run_phase(int c, int s, int w, int h, int n, bit pause_mid);
        int r;
        int ew;
        int eh;
        program_regs(c, s, w, h);
        ew = sb.side_of(sb.width_used);
        eh = sb.side_of(sb.height_used);
        if (ew < 1) ew = 1;
        if (eh < 1) eh = 1;
        for (int k = 0; k < n; k++) begin
            if (pause_mid && k == n / 2) drain_results();
            r = $urandom_range(0, 9);
            if (r < 2)
                send_word(FUNC_WRITE, 6'($urandom_range(0, ew - 1)),
                          6'($urandom_range(0, eh - 1)), 8'($urandom_range(0, 255)));
            else if (r < 3)
                send_word(FUNC_WRITE, 6'($urandom), 6'($urandom),
                          8'($urandom_range(0, 255)));
            else if (r < 9)
                send_fetch(6'($urandom_range(0, ew - 1)), 6'($urandom_range(0, eh - 1)));
            else
                send_fetch(6'($urandom), 6'($urandom));
        end
    endtask

    function automatic int rand_trig(bit want_sin, int deg);
        real a;
        a = deg * 3.14159265358979 / 180.0;
        return want_sin ? $rtoi($sin(a) * ONE_Q) : $rtoi($cos(a) * ONE_Q);
    endfunction

    // main sequence
    initial begin : stimulus
        int deg;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: identity on 64 by 64, store corners and centre
        send_word(FUNC_WRITE, 6'd0, 6'd0, 8'h00);
        send_word(FUNC_WRITE, 6'd63, 6'd63, 8'hff);
        send_word(FUNC_WRITE, 6'd63, 6'd0, 8'h81);
        send_word(FUNC_WRITE, 6'd0, 6'd63, 8'h7e);
        send_word(FUNC_WRITE, 6'd32, 6'd32, 8'h5a);
        send_fetch(6'd0, 6'd0);
        send_fetch(6'd63, 6'd63);
        send_fetch(6'd32, 6'd32);

        // scale just over one: the first column lands slightly below zero
        program_regs(ONE_Q + 1, 0, 64, 64);
        send_fetch(6'd0, 6'd0);
        send_fetch(6'd63, 6'd0);

        // quarter turn on an odd-sized bitmap: last column and row miss
        program_regs(0, ONE_Q, 63, 5);
        send_fetch(6'd62, 6'd0);
        send_fetch(6'd10, 6'd4);
        send_fetch(6'd5, 6'd2);

        // single-column bitmap: every fetch misses
        program_regs(ONE_Q, 0, 1, 64);
        send_fetch(6'd0, 6'd0);

        // sizes above the store side are clipped
        program_regs(-ONE_Q, -ONE_Q, 127, 100);
        send_fetch(6'd63, 6'd63);
        send_fetch(6'd0, 6'd31);

        // destinations outside a 10 by 10 bitmap and one at its far corner
        program_regs(ONE_Q, ONE_Q, 10, 10);
        send_fetch(6'd40, 6'd3);
        send_fetch(6'd3, 6'd40);
        send_fetch(6'd9, 6'd9);

        // random phases over several settings, extremes first
        run_phase(ONE_Q, 0, 64, 64, 150, 1'b0);
        run_phase(-ONE_Q, 0, 2, 2, 150, 1'b0);
        run_phase(0, -ONE_Q, 33, 17, 200, 1'b1);
        run_phase(-32768, 32767, 64, 64, 150, 1'b0);
        run_phase(ONE_Q, 0, 0, 64, 60, 1'b0);
        deg = $urandom_range(0, 359);
        run_phase(rand_trig(1'b0, deg), rand_trig(1'b1, deg), 127, 65, 200, 1'b0);
        repeat (4) begin
            deg = $urandom_range(0, 359);
            run_phase(rand_trig(1'b0, deg), rand_trig(1'b1, deg),
                      $urandom_range(2, 64), $urandom_range(2, 64), 100, 1'b0);
        end

        // wind down
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        sb.close_out();
        if (sb.n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/brn_pkg.sv
design/brn_ram.sv
design/brn_front.sv
design/brn_queue.sv
design/brn_back.sv
design/bitmap_rotate_nearest.sv
bench/rotate_check_pkg.sv
bench/tb_top.sv
